[rtl/bcfs_pkg.sv]
// Shared constants, types and fixed-point helpers for the banded Cholesky solver.
`default_nettype none
package bcfs_pkg;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 24;
    localparam int BAND_WIDTH = 4;
    localparam int HIST       = 3;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    localparam val_t MAXV = val_t'({1'b0, {(VALUE_BITS-1){1'b1}}});
    localparam val_t MINV = val_t'({1'b1, {(VALUE_BITS-1){1'b0}}});

    // Operation codes for the shared arithmetic unit
    localparam logic [1:0] OP_MAC  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        val_t       a;
        val_t       b;
        val_t       acc;
    } alu_req_t;

    typedef struct packed {
        logic done;
        val_t res;
    } alu_rsp_t;

    // Saturating add of two values
    function automatic val_t sat_add(input val_t x, input val_t y);
        logic signed [VALUE_BITS:0] s;
        begin
            s = {x[VALUE_BITS-1], x} + {y[VALUE_BITS-1], y};
            if (s > $signed({1'b0, MAXV})) sat_add = MAXV;
            else if (s < $signed({1'b1, MINV})) sat_add = MINV;
            else sat_add = s[VALUE_BITS-1:0];
        end
    endfunction

    // Saturating subtract x - y
    function automatic val_t sat_sub(input val_t x, input val_t y);
        logic signed [VALUE_BITS:0] s;
        begin
            s = {x[VALUE_BITS-1], x} - {y[VALUE_BITS-1], y};
            if (s > $signed({1'b0, MAXV})) sat_sub = MAXV;
            else if (s < $signed({1'b1, MINV})) sat_sub = MINV;
            else sat_sub = s[VALUE_BITS-1:0];
        end
    endfunction
endpackage
`default_nettype wire

[rtl/bcfs_alu.sv]
// Shared multi-cycle unit: rounded multiply-accumulate, fixed-point divide, square root.
`default_nettype none
module bcfs_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcfs_pkg::alu_req_t req,
    output bcfs_pkg::alu_rsp_t      rsp
);
    localparam int VB = bcfs_pkg::VALUE_BITS;
    localparam int FB = bcfs_pkg::FRAC_BITS;
    localparam int QB = VB + FB;          // quotient bits before saturation
    localparam int RB = VB + 2;           // sqrt remainder width
    localparam int SRC = 2 * VB;          // sqrt radicand bits

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 neg_reg;
    logic [VB-1:0]        ma_reg, mb_reg;
    bcfs_pkg::val_t       acc_reg;
    logic [2*VB-1:0]      prod_reg;
    logic [QB-1:0]        num_reg;    // shifts out dividend bits
    logic [QB-1:0]        quo_reg;
    logic [RB-1:0]        rem_reg;
    logic [VB-1:0]        root_reg;
    logic [SRC-1:0]       rad_reg;
    logic [5:0]           cnt_reg;
    bcfs_pkg::val_t       res_reg;

    logic [VB-1:0] amag, bmag;
    assign amag = req.a[VB-1] ? VB'(-req.a) : req.a;
    assign bmag = req.b[VB-1] ? VB'(-req.b) : req.b;

    // Rounded product magnitude, saturated
    logic [2*VB-1:0] prod_rnd;
    logic [VB-1:0]   mul_mag;
    bcfs_pkg::val_t  mul_val;
    always_comb
    begin
        prod_rnd = prod_reg + (2*VB)'(1) * (2*VB)'(1 << (FB-1));
        if (prod_rnd[2*VB-1:FB] > (2*VB-FB)'(bcfs_pkg::MAXV))
            mul_mag = VB'(bcfs_pkg::MAXV);
        else
            mul_mag = prod_rnd[FB+VB-1:FB];
        mul_val = neg_reg ? bcfs_pkg::val_t'(-mul_mag) : bcfs_pkg::val_t'(mul_mag);
    end

    // Restoring divide step
    logic [VB:0]   drem;
    logic          dfit;
    always_comb
    begin
        drem = {rem_reg[VB-1:0], num_reg[QB-1]};
        dfit = drem >= {1'b0, mb_reg};
    end

    // Square-root step on two radicand bits
    logic [RB-1:0] srem, strial;
    logic          sfit;
    always_comb
    begin
        srem   = {rem_reg[RB-3:0], rad_reg[SRC-1:SRC-2]};
        strial = {root_reg, 2'b01};
        sfit   = srem >= strial;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        bcfs_pkg::OP_MAC:  state_next = S_MUL;
                        bcfs_pkg::OP_DIV:  state_next = (req.b == '0) ? S_DONE : S_DIV;
                        bcfs_pkg::OP_SQRT: state_next = S_SQRT;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = S_DONE;
            S_DIV:  state_next = (cnt_reg == 6'(QB-1)) ? S_DONE : S_DIV;
            S_SQRT: state_next = (cnt_reg == 6'(VB-1)) ? S_DONE : S_SQRT;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                neg_reg <= req.a[VB-1] ^ req.b[VB-1];
                ma_reg  <= amag;
                mb_reg  <= bmag;
                acc_reg <= req.acc;
                num_reg <= {amag, {FB{1'b0}}};
                quo_reg <= '0;
                rem_reg <= '0;
                root_reg <= '0;
                rad_reg <= {req.a, {(SRC-VB){1'b0}}} >> (VB - FB);
                cnt_reg <= '0;
                res_reg <= '0;
            end
            S_MUL: prod_reg <= ma_reg * mb_reg;
            S_ACC: res_reg  <= bcfs_pkg::sat_add(acc_reg, mul_val);
            S_DIV:
            begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
                if (dfit)
                begin
                    rem_reg <= RB'(drem - {1'b0, mb_reg});
                    quo_reg <= {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= RB'(drem);
                    quo_reg <= {quo_reg[QB-2:0], 1'b0};
                end
            end
            S_SQRT:
            begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg + 6'd1;
                if (sfit)
                begin
                    rem_reg  <= srem - strial;
                    root_reg <= {root_reg[VB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= srem;
                    root_reg <= {root_reg[VB-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        // Finalize division and root on entering the done state
        if (state_reg == S_DIV && state_next == S_DONE)
        begin
            if ({quo_reg[QB-2:0], dfit} > QB'(bcfs_pkg::MAXV))
                res_reg <= neg_reg ? -bcfs_pkg::MAXV : bcfs_pkg::MAXV;
            else
                res_reg <= neg_reg ? bcfs_pkg::val_t'(-quo_reg[VB-2:0] * 2 - dfit)
                                   : bcfs_pkg::val_t'({quo_reg[VB-2:0], dfit});
        end
        if (state_reg == S_SQRT && state_next == S_DONE)
            res_reg <= bcfs_pkg::val_t'({root_reg[VB-2:0], sfit});
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.res  = res_reg;
endmodule
`default_nettype wire

[rtl/banded_cholesky_forward_solve_core.sv]
// Top level: row sequencer and history for the banded Cholesky forward solver.
`default_nettype none
// One matrix row enters per transaction on the s_axis side; one result leaves on
// m_axis. All arithmetic runs through one shared unit: multiply-accumulate,
// divide and square root. A row is taken only once the result of the row before
// it has been accepted, as s_axis_tready is high only while the sequencer is idle
// and the output register is empty. Values are signed Q8.24 and saturate;
// not_positive is sticky until first_row.
module banded_cholesky_forward_solve_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // band_diag[31:0], band_off_one[63:32], band_off_two[95:64],
    // band_off_three[127:96], rhs_value[159:128]
    input  wire logic [159:0] s_axis_tdata,
    // first_row
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // solution[31:0], factor_diag[62:32], zero pad [63]
    output logic [63:0]       m_axis_tdata,
    // not_positive
    output logic              m_axis_tuser
);
    typedef bcfs_pkg::val_t val_t;

    // Sequencer steps
    localparam logic [3:0] Q_IDLE = 4'd0;
    localparam logic [3:0] Q_OFF  = 4'd1;  // band entry i: accumulate
    localparam logic [3:0] Q_ODIV = 4'd2;  // band entry i: divide
    localparam logic [3:0] Q_DACC = 4'd3;  // diagonal accumulation
    localparam logic [3:0] Q_SQRT = 4'd4;
    localparam logic [3:0] Q_SACC = 4'd5;  // solution accumulation
    localparam logic [3:0] Q_SDIV = 4'd6;
    localparam logic [3:0] Q_OUT  = 4'd7;

    logic [3:0]  seq_reg;
    logic        busy_reg;        // unit request issued, waiting
    logic [1:0]  i_reg;           // band index
    logic [1:0]  k_reg;           // inner term index
    val_t        acc_reg;
    val_t        cur_reg [4];
    val_t        fh_reg  [3][4];
    val_t        sh_reg  [3];
    logic [1:0]  seen_reg;
    logic        fail_reg;
    val_t        in_reg  [5];
    logic        ovalid_reg;
    val_t        osol_reg;
    logic [30:0] odiag_reg;
    logic        oflag_reg;

    bcfs_pkg::alu_req_t req;
    bcfs_pkg::alu_rsp_t rsp;

    bcfs_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    logic accept;
    assign s_axis_tready = (seq_reg == Q_IDLE) && !ovalid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Pivot before the root
    val_t dres;
    assign dres = bcfs_pkg::sat_sub(in_reg[0], acc_reg);

    // Unit request for the current step
    always_comb
    begin
        req = '0;
        req.acc = acc_reg;
        case (seq_reg)
            Q_OFF:
            begin
                req.start = !busy_reg && ({1'b0, i_reg} <= {1'b0, seen_reg})
                            && ({1'b0, k_reg} + {1'b0, i_reg} <= 3'd3);
                req.op = bcfs_pkg::OP_MAC;
                req.a  = cur_reg[i_reg + k_reg];
                req.b  = fh_reg[i_reg - 2'd1][k_reg];
            end
            Q_ODIV:
            begin
                req.start = !busy_reg;
                req.op = bcfs_pkg::OP_DIV;
                req.a  = bcfs_pkg::sat_sub(in_reg[i_reg], acc_reg);
                req.b  = fh_reg[i_reg - 2'd1][0];
            end
            Q_DACC:
            begin
                req.start = !busy_reg;
                req.op = bcfs_pkg::OP_MAC;
                req.a  = cur_reg[i_reg];
                req.b  = cur_reg[i_reg];
            end
            Q_SQRT:
            begin
                req.start = !busy_reg && !(dres[31] || dres == '0);
                req.op = bcfs_pkg::OP_SQRT;
                req.a  = dres;
            end
            Q_SACC:
            begin
                req.start = !busy_reg;
                req.op = bcfs_pkg::OP_MAC;
                req.a  = cur_reg[i_reg];
                req.b  = sh_reg[i_reg - 2'd1];
            end
            Q_SDIV:
            begin
                req.start = !busy_reg;
                req.op = bcfs_pkg::OP_DIV;
                req.a  = bcfs_pkg::sat_sub(in_reg[4], acc_reg);
                req.b  = cur_reg[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= Q_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            seen_reg   <= '0;
            fail_reg   <= 1'b0;
            i_reg      <= '0;
            k_reg      <= '0;
            acc_reg    <= '0;
            for (int r = 0; r < 3; r++)
            begin
                sh_reg[r] <= '0;
                for (int c = 0; c < 4; c++)
                    fh_reg[r][c] <= '0;
            end
            for (int c = 0; c < 4; c++)
                cur_reg[c] <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (req.start)
                busy_reg <= 1'b1;
            if (rsp.done)
                busy_reg <= 1'b0;
            unique case (seq_reg)
                Q_IDLE:
                begin
                    if (accept)
                    begin
                        for (int f = 0; f < 5; f++)
                            in_reg[f] <= s_axis_tdata[32*f +: 32];
                        if (s_axis_tuser)
                        begin
                            seen_reg <= '0;
                            fail_reg <= 1'b0;
                            for (int r = 0; r < 3; r++)
                            begin
                                sh_reg[r] <= '0;
                                for (int c = 0; c < 4; c++)
                                    fh_reg[r][c] <= '0;
                            end
                        end
                        for (int c = 0; c < 4; c++)
                            cur_reg[c] <= '0;
                        i_reg   <= 2'd3;
                        k_reg   <= 2'd1;
                        acc_reg <= '0;
                        seq_reg <= Q_OFF;
                    end
                end
                Q_OFF:
                begin
                    // Skip entries before the first row; no terms when i = 3
                    if ({1'b0, i_reg} > {1'b0, seen_reg} && !busy_reg)
                    begin
                        cur_reg[i_reg] <= '0;
                        if (i_reg == 2'd1)
                        begin
                            i_reg <= 2'd1; acc_reg <= '0; seq_reg <= Q_DACC;
                        end
                        else
                        begin
                            i_reg <= i_reg - 2'd1; k_reg <= 2'd1; acc_reg <= '0;
                        end
                    end
                    else if ({1'b0, k_reg} + {1'b0, i_reg} > 3'd3 && !busy_reg)
                        seq_reg <= Q_ODIV;
                    else if (rsp.done)
                    begin
                        acc_reg <= rsp.res;
                        k_reg   <= k_reg + 2'd1;
                    end
                end
                Q_ODIV:
                begin
                    if (rsp.done)
                    begin
                        cur_reg[i_reg] <= rsp.res;
                        acc_reg <= '0;
                        k_reg   <= 2'd1;
                        if (i_reg == 2'd1)
                            seq_reg <= Q_DACC;
                        else
                        begin
                            i_reg <= i_reg - 2'd1;
                            seq_reg <= Q_OFF;
                        end
                    end
                end
                Q_DACC:
                begin
                    if (rsp.done)
                    begin
                        acc_reg <= rsp.res;
                        if (i_reg == 2'd3)
                            seq_reg <= Q_SQRT;
                        i_reg <= i_reg + 2'd1;
                    end
                end
                Q_SQRT:
                begin
                    // Check pivot before issuing the root
                    if (!busy_reg && (dres[31] || dres == '0))
                    begin
                        fail_reg   <= 1'b1;
                        cur_reg[0] <= '0;
                        acc_reg    <= '0;
                        i_reg      <= 2'd1;
                        seq_reg    <= Q_SACC;
                    end
                    else if (rsp.done)
                    begin
                        cur_reg[0] <= rsp.res;
                        acc_reg    <= '0;
                        i_reg      <= 2'd1;
                        seq_reg    <= Q_SACC;
                    end
                end
                Q_SACC:
                begin
                    if (rsp.done)
                    begin
                        acc_reg <= rsp.res;
                        if (i_reg == 2'd3)
                            seq_reg <= Q_SDIV;
                        i_reg <= i_reg + 2'd1;
                    end
                end
                Q_SDIV:
                begin
                    if (rsp.done)
                    begin
                        osol_reg <= rsp.res;
                        sh_reg[2] <= sh_reg[1];
                        sh_reg[1] <= sh_reg[0];
                        sh_reg[0] <= rsp.res;
                        for (int c = 0; c < 4; c++)
                        begin
                            fh_reg[2][c] <= fh_reg[1][c];
                            fh_reg[1][c] <= fh_reg[0][c];
                            fh_reg[0][c] <= cur_reg[c];
                        end
                        if (seen_reg != 2'd3)
                            seen_reg <= seen_reg + 2'd1;
                        seq_reg <= Q_OUT;
                    end
                end
                Q_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    seq_reg    <= Q_IDLE;
                end
                default: seq_reg <= Q_IDLE;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (seq_reg == Q_OUT)
        begin
            odiag_reg <= cur_reg[0][30:0];
            oflag_reg <= fail_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, odiag_reg, osol_reg};
    assign m_axis_tuser  = oflag_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != Q_IDLE |-> !s_axis_tready)
        else $error("input ready while sequencer busy");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(seq_reg) == Q_OUT)
        else $error("result raised outside output step");
    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg == 2'd3 && seq_reg == Q_SDIV && rsp.done |=> seen_reg == 2'd3)
        else $error("row counter wrapped");
`endif
endmodule
`default_nettype wire

[tb/sv/banded_cholesky_forward_solve_core_test.sv]
// Self-checking testbench for the banded Cholesky forward-solve core.
`default_nettype none
module banded_cholesky_forward_solve_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ONE        = 32'h0100_0000;
    localparam int          CYCLE_CAP  = 5_000_000;
    localparam int          LONG_HOLD  = 3000;
    localparam int          RANDOM_ROWS = 1930;

    typedef struct {
        bit             first;
        bcfs_pkg::val_t diag;
        bcfs_pkg::val_t off1;
        bcfs_pkg::val_t off2;
        bcfs_pkg::val_t off3;
        bcfs_pkg::val_t rhs;
    } row_t;

    typedef struct {
        logic [31:0] sol;
        logic [30:0] fd;
        logic        np;
    } res_t;

    // Directed row with an optional hand-typed result
    typedef struct {
        row_t row;
        bit   typed;
        res_t res;
    } plan_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    banded_cholesky_forward_solve_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: last three factor rows and solutions
    longint factor_rows [bcfs_pkg::HIST][bcfs_pkg::BAND_WIDTH];
    longint solved_vals [bcfs_pkg::HIST];
    int     rows_in_system;
    bit     pivot_failed;

    res_t   pending_results [$];
    int     errors;
    int     cycles;
    int     idle_pct;
    int     stall_pct;
    bit     want_hold;
    int     hold_left;

    always #5 clk = ~clk;

    function automatic longint clamp(input longint v);
        if (v > longint'(bcfs_pkg::MAXV)) return longint'(bcfs_pkg::MAXV);
        if (v < longint'(bcfs_pkg::MINV)) return longint'(bcfs_pkg::MINV);
        return v;
    endfunction

    // Round-to-nearest fixed-point product, saturated to +-MAXV
    function automatic longint fx_mul(input longint a, input longint b);
        bit              neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = ma * mb;
        p = (p + (64'd1 << (bcfs_pkg::FRAC_BITS - 1))) >> bcfs_pkg::FRAC_BITS;
        if (p > longint'(bcfs_pkg::MAXV)) p = longint'(bcfs_pkg::MAXV);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Truncating fixed-point quotient; zero divisor gives zero
    function automatic longint fx_div(input longint num, input longint den);
        bit              neg;
        longint unsigned m;
        longint unsigned d;
        longint unsigned q;
        if (den == 0) return 0;
        neg = (num < 0) != (den < 0);
        m = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (m / d > (longint'(bcfs_pkg::MAXV) >> bcfs_pkg::FRAC_BITS))
            return neg ? -longint'(bcfs_pkg::MAXV) : longint'(bcfs_pkg::MAXV);
        q = (m << bcfs_pkg::FRAC_BITS) / d;
        if (q > longint'(bcfs_pkg::MAXV)) q = longint'(bcfs_pkg::MAXV);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Floor of the fixed-point square root of a positive value
    function automatic longint fx_sqrt(input longint v);
        longint unsigned n;
        longint unsigned root;
        longint unsigned probe;
        n = longint'(v) << bcfs_pkg::FRAC_BITS;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return longint'(root);
    endfunction

    function automatic void clear_system();
        foreach (factor_rows[i, j]) factor_rows[i][j] = 0;
        foreach (solved_vals[i]) solved_vals[i] = 0;
        rows_in_system = 0;
        pivot_failed = 0;
    endfunction

    // Factor one row, solve its element and advance the history
    function automatic res_t solve_row(input row_t r);
        longint cur [bcfs_pkg::BAND_WIDTH];
        longint off [bcfs_pkg::BAND_WIDTH];
        longint acc;
        longint x;
        res_t   res;
        if (r.first) clear_system();
        off[0] = r.diag;
        off[1] = r.off1;
        off[2] = r.off2;
        off[3] = r.off3;
        for (int i = bcfs_pkg::BAND_WIDTH - 1; i >= 1; i--) begin
            cur[i] = 0;
            if (i > rows_in_system) continue;
            acc = 0;
            for (int k = 1; k < bcfs_pkg::BAND_WIDTH - i; k++)
                acc = clamp(acc + fx_mul(cur[i + k], factor_rows[i - 1][k]));
            cur[i] = fx_div(clamp(off[i] - acc), factor_rows[i - 1][0]);
        end
        acc = 0;
        for (int i = 1; i < bcfs_pkg::BAND_WIDTH; i++)
            acc = clamp(acc + fx_mul(cur[i], cur[i]));
        acc = clamp(off[0] - acc);
        if (acc <= 0) begin
            pivot_failed = 1;
            cur[0] = 0;
        end
        else begin
            cur[0] = fx_sqrt(acc);
        end
        acc = 0;
        for (int i = 1; i < bcfs_pkg::BAND_WIDTH; i++)
            acc = clamp(acc + fx_mul(cur[i], solved_vals[i - 1]));
        x = fx_div(clamp(longint'(r.rhs) - acc), cur[0]);
        for (int i = bcfs_pkg::HIST - 1; i >= 1; i--) begin
            factor_rows[i] = factor_rows[i - 1];
            solved_vals[i] = solved_vals[i - 1];
        end
        for (int j = 0; j < bcfs_pkg::BAND_WIDTH; j++) factor_rows[0][j] = cur[j];
        solved_vals[0] = x;
        if (rows_in_system < bcfs_pkg::HIST) rows_in_system++;
        res.sol = x[31:0];
        res.fd = cur[0][30:0];
        res.np = pivot_failed;
        return res;
    endfunction

    function automatic row_t make_row(input bit first, input bcfs_pkg::val_t diag,
                                      input bcfs_pkg::val_t o1, input bcfs_pkg::val_t o2,
                                      input bcfs_pkg::val_t o3, input bcfs_pkg::val_t rhs);
        row_t r;
        r.first = first;
        r.diag = diag;
        r.off1 = o1;
        r.off2 = o2;
        r.off3 = o3;
        r.rhs = rhs;
        return r;
    endfunction

    // Mostly well-conditioned systems with random content, some raw noise
    function automatic row_t random_row();
        row_t r;
        if ($urandom_range(99) < 85) begin
            r.first = ($urandom_range(11) == 0);
            r.diag = $urandom_range(32'h0800_0000, 32'h0100_0000);
            r.off1 = int'($urandom_range(32'h0200_0000)) - int'(ONE);
            r.off2 = int'($urandom_range(32'h0200_0000)) - int'(ONE);
            r.off3 = int'($urandom_range(32'h0200_0000)) - int'(ONE);
            r.rhs = $urandom;
        end
        else begin
            r.first = $urandom_range(1);
            r.diag = $urandom;
            r.off1 = $urandom;
            r.off2 = $urandom;
            r.off3 = $urandom;
            r.rhs = $urandom;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Offer one row, hold it until accepted, then queue its result
    task automatic send_row(input row_t r, input bit typed, input res_t typed_res);
        res_t res;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 0;
            @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser = r.first;
        s_axis_tdata = {r.rhs, r.off3, r.off2, r.off1, r.diag};
        do @(posedge clk); while (!s_axis_tready);
        res = solve_row(r);
        pending_results.push_back(typed ? typed_res : res);
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Receiver ready, with random stalls and a long hold-off on request
    always @(negedge clk) begin
        if (want_hold) begin
            want_hold = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 0;
        end
        else begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk) begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end
            else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.sol)
                    report_mismatch("solution", m_axis_tdata[31:0], want.sol);
                if (m_axis_tdata[62:32] !== want.fd)
                    report_mismatch("factor_diag", m_axis_tdata[62:32], want.fd);
                if (m_axis_tuser !== want.np)
                    report_mismatch("not_positive", m_axis_tuser, want.np);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("banded_cholesky_forward_solve_core_test failed");
            $finish;
        end
    end

    initial begin
        plan_t plan [$];
        plan_t p;
        res_t  none;
        int    phase_idle [4];
        int    phase_stall [4];
        none = '{sol: 0, fd: 0, np: 0};
        phase_idle = '{0, 47, 0, 37};
        phase_stall = '{0, 0, 47, 37};
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        errors = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        want_hold = 0;
        hold_left = 0;
        clear_system();

        // No first row after reset: off-diagonals reach before the system
        plan.push_back('{make_row(0, ONE, bcfs_pkg::MAXV, bcfs_pkg::MAXV, bcfs_pkg::MAXV,
                                  32'h0200_0000), 1,
                         '{sol: 32'h0200_0000, fd: 31'h0100_0000, np: 0}});
        // Zero pivot: flag set, diagonal and solution zero
        plan.push_back('{make_row(1, 0, 0, 0, 0, ONE), 1, '{sol: 0, fd: 0, np: 1}});
        // Divide by the zero diagonal of the failed row; flag stays set
        plan.push_back('{make_row(0, 32'h0400_0000, 32'h0500_0000, 0, 0, ONE), 1,
                         '{sol: 32'h0080_0000, fd: 31'h0200_0000, np: 1}});
        // Negative pivot on a new system
        plan.push_back('{make_row(1, -int'(ONE), 0, 0, 0, bcfs_pkg::MAXV), 1,
                         '{sol: 0, fd: 0, np: 1}});
        // Extremes of the fields
        plan.push_back('{make_row(1, bcfs_pkg::MAXV, bcfs_pkg::MINV, bcfs_pkg::MINV,
                                  bcfs_pkg::MINV, bcfs_pkg::MAXV), 0, none});
        plan.push_back('{make_row(0, bcfs_pkg::MAXV, bcfs_pkg::MAXV, bcfs_pkg::MINV,
                                  bcfs_pkg::MAXV, bcfs_pkg::MINV), 0, none});
        plan.push_back('{make_row(0, bcfs_pkg::MINV, bcfs_pkg::MAXV, bcfs_pkg::MAXV,
                                  bcfs_pkg::MAXV, bcfs_pkg::MINV), 0, none});
        plan.push_back('{make_row(0, bcfs_pkg::MAXV, bcfs_pkg::MINV, bcfs_pkg::MAXV,
                                  bcfs_pkg::MINV, bcfs_pkg::MAXV), 0, none});
        plan.push_back('{make_row(1, 1, -1, -1, -1, -1), 0, none});
        plan.push_back('{make_row(0, 1, 1, 1, 1, 1), 0, none});
        // A well-conditioned chain that fills the whole band
        for (int i = 0; i < 6; i++)
            plan.push_back('{make_row(i == 0, 32'h0400_0000, ONE, 32'h0080_0000,
                                      32'h0040_0000, int'(ONE) * (i - 2)), 0, none});
        // Pivot failure in the middle of a filled band, then recovery
        plan.push_back('{make_row(0, 32'h0000_1000, bcfs_pkg::MAXV, bcfs_pkg::MAXV,
                                  bcfs_pkg::MAXV, ONE), 0, none});
        plan.push_back('{make_row(0, 32'h0400_0000, ONE, ONE, ONE, ONE), 0, none});
        plan.push_back('{make_row(1, 32'h0400_0000, ONE, ONE, ONE, ONE), 0, none});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (plan[i]) begin
            p = plan[i];
            send_row(p.row, p.typed, p.res);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            // Receiver holds off while rows keep being offered
            if (ph == 1) want_hold = 1;
            for (int n = 0; n < RANDOM_ROWS / 4; n++)
                send_row(random_row(), 0, none);
            // Sender pauses until every result is back
            drain();
        end

        stall_pct = 0;
        drain();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("banded_cholesky_forward_solve_core_test passed");
        else
            $display("banded_cholesky_forward_solve_core_test failed");
        $finish;
    end
endmodule
`default_nettype wire

[banded_cholesky_forward_solve_core.f]
rtl/bcfs_pkg.sv
rtl/bcfs_alu.sv
rtl/banded_cholesky_forward_solve_core.sv
tb/sv/banded_cholesky_forward_solve_core_test.sv
